### sv/rsd_pkg.sv
`default_nettype none
package rsd_pkg;

	localparam int unsigned ID_W    = 32;
	localparam int unsigned SCORE_W = 10;
	localparam int unsigned RANK_W  = 6;
	// arrival number within a set; covers capacities up to 1024
	localparam int unsigned SEQ_W   = 10;
	localparam int unsigned IN_TDATA_W  = 48;
	localparam int unsigned OUT_TDATA_W = 48;

	// one record slot as it moves along the chain
	typedef struct packed {
		logic               v;
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] score;
		logic [SEQ_W-1:0]   seq;
	} rec_t;

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_FLUSH = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

endpackage
`default_nettype wire

### sv/rsd_cell.sv
`default_nettype none
module rsd_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 shift,
	input  rsd_pkg::rec_t       pass_in,
	input  rsd_pkg::rec_t       right_in,
	output rsd_pkg::rec_t       held,
	output rsd_pkg::rec_t       pass_out
);

	rsd_pkg::rec_t held_q;
	rsd_pkg::rec_t pass_q;
	rsd_pkg::rec_t held_d;
	rsd_pkg::rec_t pass_d;
	logic          wins;

	// incoming record wins the slot on a higher score, or on an equal score
	// with an earlier arrival number; a displaced record can be older than
	// equal scores settled further down, so the score alone is not enough
	assign wins = (pass_in.score > held_q.score) ||
		((pass_in.score == held_q.score) && (pass_in.seq < held_q.seq));

	always_comb begin
		held_d   = held_q;
		pass_d   = pass_in;
		pass_d.v = 1'b0;
		if (shift) begin
			held_d = right_in;
		end else if (pass_in.v) begin
			if (!held_q.v) begin
				held_d = pass_in;
			end else if (wins) begin
				held_d = pass_in;
				pass_d = held_q;
			end else begin
				pass_d = pass_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pass_q <= '0;
		end else begin
			held_q <= held_d;
			pass_q <= pass_d;
		end
	end

	assign held     = held_q;
	assign pass_out = pass_q;

endmodule
`default_nettype wire

### sv/record_sort_by_score_desc_unit.sv
`default_nettype none
// Stable descending sort of a set of records (id, score in tenths).
// Slave stream: one record per transfer, tlast on the final record of a set.
// Records enter a chain of MAX_RECORDS compare-and-swap cells, one transfer
// per cycle, while the set is loading. Records beyond MAX_RECORDS are
// dropped; a dropped record carrying tlast still closes the set.
// After the tlast transfer the chain settles for as long as a record needs
// to walk the whole chain, then the records are shifted out of the head
// cell, highest score first, equal scores in arrival order.
// Master stream: rank, id and score per transfer, tlast on the lowest rank.
// Output runs at one transfer per cycle; a stall on m_axis_tready simply
// holds the chain. Input is not accepted from the tlast transfer until the
// last result has gone; a set loads at one record per cycle.
// Reset empties the chain and returns the block to loading.
module record_sort_by_score_desc_unit #(
	parameter int unsigned MAX_RECORDS = 64
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	// record_id[31:0], score_tenths[41:32], zero pad[47:42]
	input  wire  [rsd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	input  wire                               s_axis_tlast,   // last_record
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// rank[5:0], out_id[37:6], out_score[47:38]
	output logic [rsd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic                              m_axis_tlast    // last_result
);

	localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_RECORDS);

	rsd_pkg::state_t state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   flush_q;
	logic [rsd_pkg::RANK_W-1:0] rank_q;
	rsd_pkg::rec_t   ins_q;

	rsd_pkg::rec_t   chain   [MAX_RECORDS+1];
	rsd_pkg::rec_t   held    [MAX_RECORDS+1];

	logic in_xfer;
	logic out_xfer;
	logic shift;

	assign s_axis_tready = (state_q == rsd_pkg::ST_LOAD);
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == rsd_pkg::ST_DRAIN) && held[0].v;
	assign out_xfer = m_axis_tvalid && m_axis_tready;
	assign shift    = out_xfer;

	assign chain[0] = ins_q;
	assign held[MAX_RECORDS] = '0;

	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		rsd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (shift),
			.pass_in  (chain[i]),
			.right_in (held[i+1]),
			.held     (held[i]),
			.pass_out (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsd_pkg::ST_LOAD;
			count_q <= '0;
			flush_q <= '0;
			rank_q  <= '0;
			ins_q   <= '0;
		end else begin
			ins_q <= '{
				v:     in_xfer && (count_q != MAX_C),
				id:    s_axis_tdata[rsd_pkg::ID_W-1:0],
				score: s_axis_tdata[rsd_pkg::ID_W +: rsd_pkg::SCORE_W],
				seq:   rsd_pkg::SEQ_W'(count_q)
			};
			unique case (state_q)
				rsd_pkg::ST_LOAD: begin
					if (in_xfer) begin
						if (count_q != MAX_C) begin
							count_q <= count_q + CW'(1);
						end
						if (s_axis_tlast) begin
							state_q <= rsd_pkg::ST_FLUSH;
							flush_q <= '0;
						end
					end
				end
				rsd_pkg::ST_FLUSH: begin
					flush_q <= flush_q + CW'(1);
					if (flush_q == MAX_C) begin
						state_q <= rsd_pkg::ST_DRAIN;
						rank_q  <= '0;
					end
				end
				rsd_pkg::ST_DRAIN: begin
					if (out_xfer) begin
						rank_q <= rank_q + rsd_pkg::RANK_W'(1);
						if (!held[1].v) begin
							state_q <= rsd_pkg::ST_LOAD;
							count_q <= '0;
						end
					end
				end
				default: begin
					state_q <= rsd_pkg::ST_LOAD;
				end
			endcase
		end
	end

	assign m_axis_tdata = {held[0].score, held[0].id, rank_q};
	assign m_axis_tlast = !held[1].v;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_C)
		else $error("record count above capacity");

	a_drain_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rsd_pkg::ST_DRAIN) && held[0].v && held[1].v
		|-> held[0].score >= held[1].score)
		else $error("chain head out of order");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == rsd_pkg::ST_DRAIN) |-> held[0].v)
		else $error("drain started with empty chain");

	a_no_input_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != rsd_pkg::ST_LOAD) |-> !ins_q.v || $past(in_xfer))
		else $error("record entered chain outside load");

	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rsd_pkg::ST_DRAIN) && out_xfer && m_axis_tlast
		|=> (state_q == rsd_pkg::ST_LOAD) && !held[0].v)
		else $error("chain not empty after final result");

endmodule
`default_nettype wire
